FILE: design/assert_macros.svh
// Assertion macros used by the request head checker top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst, pre, post, msg)
`define ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

FILE: design/hrhc_pkg.sv
// Types, codes and character tables of the request head checker.
`default_nettype none
package hrhc_pkg;

  typedef enum logic [4:0] {
    ST_METHOD     = 5'd0,
    ST_PATH_START = 5'd1,
    ST_PATH       = 5'd2,
    ST_VER0       = 5'd3,
    ST_VER1       = 5'd4,
    ST_VER2       = 5'd5,
    ST_VER3       = 5'd6,
    ST_VER4       = 5'd7,
    ST_VER5       = 5'd8,
    ST_VER6       = 5'd9,
    ST_VER7       = 5'd10,
    ST_LINE_CR    = 5'd11,
    ST_LINE_LF    = 5'd12,
    ST_NAME_START = 5'd13,
    ST_NAME       = 5'd14,
    ST_COLON_SP   = 5'd15,
    ST_VAL_START  = 5'd16,
    ST_VAL        = 5'd17,
    ST_HDR_LF     = 5'd18,
    ST_LAST_LF    = 5'd19,
    ST_DONE       = 5'd20,
    ST_ERROR      = 5'd21
  } parse_state_t;

  typedef enum logic [2:0] {
    FIELD_NONE   = 3'd0,
    FIELD_METHOD = 3'd1,
    FIELD_PATH   = 3'd2,
    FIELD_NAME   = 3'd3,
    FIELD_VALUE  = 3'd4
  } field_t;

  typedef enum logic [1:0] {
    STATUS_PARSING  = 2'd0,
    STATUS_COMPLETE = 2'd1,
    STATUS_ERROR    = 2'd2
  } status_t;

  typedef struct packed {
    parse_state_t nx;
    field_t       kind;
    field_t       ended;
    status_t      status;
  } step_t;

  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_DEL   = 8'h7F;

  localparam logic [7:0] VERSION_TEXT [8] = '{
    8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h31, 8'h2E, 8'h31
  };

  // Bit c[2:0] of entry c[6:3] marks a header name byte.
  localparam logic [7:0] NAME_BITS [16] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'hFB, 8'h6C, 8'hFF, 8'h03,
    8'hFE, 8'hFF, 8'hFF, 8'hC7, 8'hFF, 8'hFF, 8'hFF, 8'h57
  };

  function automatic logic is_name_byte(input logic [7:0] c);
    logic [7:0] row;
    row = NAME_BITS[c[6:3]];
    return !c[7] && row[c[2:0]];
  endfunction

  function automatic logic is_value_byte(input logic [7:0] c);
    return (c == CHAR_TAB) || ((c > 8'd31) && (c != CHAR_DEL));
  endfunction

  function automatic logic is_path_byte(input logic [7:0] c);
    return (c >= 8'd33) && (c <= 8'd126);
  endfunction

endpackage
`default_nettype wire

FILE: design/hrhc_step.sv
// Next-state and result logic of the request head grammar for one byte.
`default_nettype none
module hrhc_step (
  input  wire logic [7:0]           data_byte,
  input  wire logic                 restart,
  input  wire hrhc_pkg::parse_state_t state,
  output hrhc_pkg::step_t           step
);
  import hrhc_pkg::*;

  parse_state_t s;
  parse_state_t nx;
  field_t       kind;
  field_t       ended;
  logic [2:0]   ver_idx;

  assign s       = restart ? ST_METHOD : state;
  assign ver_idx = 3'(s - ST_VER0);

  always_comb begin
    nx    = ST_ERROR;
    kind  = FIELD_NONE;
    ended = FIELD_NONE;
    case (s)
      ST_METHOD: begin
        if (data_byte == CHAR_SPACE) begin
          ended = FIELD_METHOD;
          nx    = ST_PATH_START;
        end else if (data_byte >= 8'h41 && data_byte <= 8'h5A) begin
          kind = FIELD_METHOD;
          nx   = ST_METHOD;
        end
      end
      ST_PATH_START: begin
        if (data_byte == CHAR_SLASH) begin
          kind = FIELD_PATH;
          nx   = ST_PATH;
        end
      end
      ST_PATH: begin
        if (data_byte == CHAR_SPACE) begin
          ended = FIELD_PATH;
          nx    = ST_VER0;
        end else if (is_path_byte(data_byte)) begin
          kind = FIELD_PATH;
          nx   = ST_PATH;
        end
      end
      ST_VER0, ST_VER1, ST_VER2, ST_VER3, ST_VER4, ST_VER5, ST_VER6, ST_VER7: begin
        if (data_byte == VERSION_TEXT[ver_idx]) begin
          nx = parse_state_t'(s + 5'd1);
        end
      end
      ST_LINE_CR: begin
        if (data_byte == CHAR_CR) begin
          nx = ST_LINE_LF;
        end
      end
      ST_LINE_LF, ST_HDR_LF: begin
        if (data_byte == CHAR_LF) begin
          nx = ST_NAME_START;
        end
      end
      ST_NAME_START: begin
        if (data_byte == CHAR_CR) begin
          nx = ST_LAST_LF;
        end else if (is_name_byte(data_byte)) begin
          kind = FIELD_NAME;
          nx   = ST_NAME;
        end
      end
      ST_NAME: begin
        if (data_byte == CHAR_COLON) begin
          ended = FIELD_NAME;
          nx    = ST_COLON_SP;
        end else if (is_name_byte(data_byte)) begin
          kind = FIELD_NAME;
          nx   = ST_NAME;
        end
      end
      ST_COLON_SP: begin
        if (data_byte == CHAR_SPACE) begin
          nx = ST_VAL_START;
        end
      end
      ST_VAL_START: begin
        if (is_value_byte(data_byte)) begin
          kind = FIELD_VALUE;
          nx   = ST_VAL;
        end
      end
      ST_VAL: begin
        if (data_byte == CHAR_CR) begin
          ended = FIELD_VALUE;
          nx    = ST_HDR_LF;
        end else if (is_value_byte(data_byte)) begin
          kind = FIELD_VALUE;
          nx   = ST_VAL;
        end
      end
      ST_LAST_LF: begin
        if (data_byte == CHAR_LF) begin
          nx = ST_DONE;
        end
      end
      ST_DONE: begin
        nx = ST_DONE;
      end
      default: begin
        nx = ST_ERROR;
      end
    endcase
  end

  always_comb begin
    step.nx     = nx;
    step.kind   = kind;
    step.ended  = ended;
    step.status = STATUS_PARSING;
    if (nx == ST_ERROR) begin
      step.kind   = FIELD_NONE;
      step.ended  = FIELD_NONE;
      step.status = STATUS_ERROR;
    end else if (nx == ST_DONE) begin
      step.status = STATUS_COMPLETE;
    end
    if (s == ST_DONE) begin
      step.kind  = FIELD_NONE;
      step.ended = FIELD_NONE;
    end
  end

endmodule
`default_nettype wire

FILE: design/http_request_head_checker_top.sv
// Top level of the request head checker: parse state and result register.
// Each accepted item gives one result in the cycle after it is taken, in the output register.
// Throughput is one item per cycle while the output is not stalled; the only loop is the parse state register.
// An item is taken whenever the output register is empty or its result leaves.
// Synchronous reset returns the parser to the method state and empties the output.
`default_nettype none
`include "assert_macros.svh"
module http_request_head_checker_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] data_byte,
  input  wire logic       restart,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      byte_out,
  output logic [2:0]      field_kind,
  output logic [2:0]      ended_field,
  output logic [1:0]      status
);
  import hrhc_pkg::*;

  parse_state_t state;
  step_t        step;
  logic         in_accept;
  logic [7:0]   byte_reg;
  field_t       kind_reg;
  field_t       ended_reg;
  status_t      status_reg;

  hrhc_step u_step (
    .data_byte (data_byte),
    .restart   (restart),
    .state     (state),
    .step      (step)
  );

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_METHOD;
      out_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        state     <= step.nx;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      byte_reg   <= data_byte;
      kind_reg   <= step.kind;
      ended_reg  <= step.ended;
      status_reg <= step.status;
    end
  end

  assign byte_out    = byte_reg;
  assign field_kind  = kind_reg;
  assign ended_field = ended_reg;
  assign status      = status_reg;

  `ASSERT_IMPLY(a_error_no_tags, clk, rst, out_valid && status_reg == STATUS_ERROR, kind_reg == FIELD_NONE && ended_reg == FIELD_NONE, "Error result carries a field tag.")
  `ASSERT_IMPLY(a_tag_exclusive, clk, rst, out_valid && kind_reg != FIELD_NONE, ended_reg == FIELD_NONE, "Result is both content and delimiter.")
  `ASSERT_NEXT(a_error_sticks, clk, rst, in_accept && !restart && state == ST_ERROR, out_valid && status_reg == STATUS_ERROR && state == ST_ERROR, "Error state did not stick.")
  `ASSERT_NEXT(a_done_sticks, clk, rst, in_accept && !restart && state == ST_DONE, out_valid && status_reg == STATUS_COMPLETE && state == ST_DONE, "Complete state did not stick.")

endmodule
`default_nettype wire

FILE: tb/sv/tb_http_request_head_checker_top.sv
// Self-checking testbench for the HTTP/1.1 request head checker with random flow control.
`timescale 1ns / 100ps
module tb_http_request_head_checker_top;
  import hrhc_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       rs;
    logic       typed;
    field_t     kind;
    field_t     ended;
    status_t    status;
  } step_row_t;

  typedef struct packed {
    logic [7:0] data;
    field_t     kind;
    field_t     ended;
    status_t    status;
  } byte_tag_t;

  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_ITEMS = 600;

  // The expected tags of every directed row follow directly from the head grammar.
  localparam step_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{CHAR_SPACE, 1'b1, 1'b1, FIELD_NONE, FIELD_METHOD, STATUS_PARSING},
    '{CHAR_SLASH, 1'b0, 1'b1, FIELD_PATH, FIELD_NONE, STATUS_PARSING},
    '{8'h7E, 1'b0, 1'b1, FIELD_PATH, FIELD_NONE, STATUS_PARSING},
    '{CHAR_SPACE, 1'b0, 1'b1, FIELD_NONE, FIELD_PATH, STATUS_PARSING},
    '{8'h48, 1'b0, 1'b1, FIELD_NONE, FIELD_NONE, STATUS_PARSING},
    '{8'h54, 1'b0, 1'b1, FIELD_NONE, FIELD_NONE, STATUS_PARSING},
    '{8'h54, 1'b0, 1'b1, FIELD_NONE, FIELD_NONE, STATUS_PARSING},
    '{8'h50, 1'b0, 1'b1, FIELD_NONE, FIELD_NONE, STATUS_PARSING},
    '{8'h2F, 1'b0, 1'b1, FIELD_NONE, FIELD_NONE, STATUS_PARSING},
    '{8'h31, 1'b0, 1'b1, FIELD_NONE, FIELD_NONE, STATUS_PARSING},
    '{8'h2E, 1'b0, 1'b1, FIELD_NONE, FIELD_NONE, STATUS_PARSING},
    '{8'h31, 1'b0, 1'b1, FIELD_NONE, FIELD_NONE, STATUS_PARSING},
    '{CHAR_CR, 1'b0, 1'b1, FIELD_NONE, FIELD_NONE, STATUS_PARSING},
    '{CHAR_LF, 1'b0, 1'b1, FIELD_NONE, FIELD_NONE, STATUS_PARSING},
    '{CHAR_SPACE, 1'b0, 1'b1, FIELD_NAME, FIELD_NONE, STATUS_PARSING},
    '{CHAR_COLON, 1'b0, 1'b1, FIELD_NONE, FIELD_NAME, STATUS_PARSING},
    '{CHAR_SPACE, 1'b0, 1'b1, FIELD_NONE, FIELD_NONE, STATUS_PARSING},
    '{8'hFF, 1'b0, 1'b1, FIELD_VALUE, FIELD_NONE, STATUS_PARSING},
    '{CHAR_CR, 1'b0, 1'b1, FIELD_NONE, FIELD_VALUE, STATUS_PARSING},
    '{CHAR_LF, 1'b0, 1'b1, FIELD_NONE, FIELD_NONE, STATUS_PARSING},
    '{CHAR_CR, 1'b0, 1'b1, FIELD_NONE, FIELD_NONE, STATUS_PARSING},
    '{CHAR_LF, 1'b0, 1'b1, FIELD_NONE, FIELD_NONE, STATUS_COMPLETE},
    '{8'h00, 1'b0, 1'b1, FIELD_NONE, FIELD_NONE, STATUS_COMPLETE},
    '{CHAR_DEL, 1'b1, 1'b1, FIELD_NONE, FIELD_NONE, STATUS_ERROR},
    '{8'h41, 1'b0, 1'b1, FIELD_NONE, FIELD_NONE, STATUS_ERROR}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte = 8'h00;
  logic       restart = 1'b0;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] byte_out;
  logic [2:0] field_kind;
  logic [2:0] ended_field;
  logic [1:0] status;

  logic       rx_stall = 1'b0;
  logic       hold_off = 1'b0;

  step_row_t    req_bytes [$];
  byte_tag_t    pending_tags [$];
  parse_state_t grammar_pos = ST_METHOD;
  int           tx_calm = 0;
  int           rx_calm = 0;
  int           n_sent = 0;
  int           n_checked = 0;
  int           n_errors = 0;
  int           n_heads = 0;
  int           n_rejects = 0;

  assign out_stall = rx_stall | hold_off;

  http_request_head_checker_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .restart     (restart),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .byte_out    (byte_out),
    .field_kind  (field_kind),
    .ended_field (ended_field),
    .status      (status)
  );

  always #2 clk = ~clk;

  function automatic logic name_char(input logic [7:0] c);
    if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9")) begin
      return 1'b1;
    end
    case (c)
      " ", "!", "#", "$", "%", "&", "'", "*", "+", "-", ".", "^", "_", 8'h60, "|", "~": begin
        return 1'b1;
      end
      default: begin
        return 1'b0;
      end
    endcase
  endfunction

  function automatic logic value_char(input logic [7:0] c);
    return (c == CHAR_TAB) || (c >= 8'd32 && c != CHAR_DEL);
  endfunction

  function automatic logic [7:0] any_name_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 127)); while (!name_char(c));
    return c;
  endfunction

  function automatic logic [7:0] any_value_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (!value_char(c));
    return c;
  endfunction

  // Tags one byte against the head grammar and advances the grammar position.
  function automatic byte_tag_t classify_byte(input logic [7:0] c, input logic rs);
    byte_tag_t    r;
    parse_state_t s;
    parse_state_t nx;
    r.data = c;
    r.kind = FIELD_NONE;
    r.ended = FIELD_NONE;
    r.status = STATUS_PARSING;
    if (rs) grammar_pos = ST_METHOD;
    s = grammar_pos;
    nx = ST_ERROR;
    if (s >= ST_VER0 && s <= ST_VER7) begin
      if (c == VERSION_TEXT[s - ST_VER0]) nx = parse_state_t'(s + 5'd1);
    end else begin
      case (s)
        ST_METHOD: begin
          if (c == CHAR_SPACE) begin
            r.ended = FIELD_METHOD;
            nx = ST_PATH_START;
          end else if (c >= "A" && c <= "Z") begin
            r.kind = FIELD_METHOD;
            nx = ST_METHOD;
          end
        end
        ST_PATH_START: begin
          if (c == CHAR_SLASH) begin
            r.kind = FIELD_PATH;
            nx = ST_PATH;
          end
        end
        ST_PATH: begin
          if (c == CHAR_SPACE) begin
            r.ended = FIELD_PATH;
            nx = ST_VER0;
          end else if (c >= 8'd33 && c <= 8'd126) begin
            r.kind = FIELD_PATH;
            nx = ST_PATH;
          end
        end
        ST_LINE_CR: begin
          if (c == CHAR_CR) nx = ST_LINE_LF;
        end
        ST_LINE_LF, ST_HDR_LF: begin
          if (c == CHAR_LF) nx = ST_NAME_START;
        end
        ST_NAME_START: begin
          if (c == CHAR_CR) begin
            nx = ST_LAST_LF;
          end else if (name_char(c)) begin
            r.kind = FIELD_NAME;
            nx = ST_NAME;
          end
        end
        ST_NAME: begin
          if (c == CHAR_COLON) begin
            r.ended = FIELD_NAME;
            nx = ST_COLON_SP;
          end else if (name_char(c)) begin
            r.kind = FIELD_NAME;
            nx = ST_NAME;
          end
        end
        ST_COLON_SP: begin
          if (c == CHAR_SPACE) nx = ST_VAL_START;
        end
        ST_VAL_START: begin
          if (value_char(c)) begin
            r.kind = FIELD_VALUE;
            nx = ST_VAL;
          end
        end
        ST_VAL: begin
          if (c == CHAR_CR) begin
            r.ended = FIELD_VALUE;
            nx = ST_HDR_LF;
          end else if (value_char(c)) begin
            r.kind = FIELD_VALUE;
            nx = ST_VAL;
          end
        end
        ST_LAST_LF: begin
          if (c == CHAR_LF) nx = ST_DONE;
        end
        ST_DONE: begin
          nx = ST_DONE;
        end
        default: begin
          nx = ST_ERROR;
        end
      endcase
    end
    if (nx == ST_ERROR) begin
      r.kind = FIELD_NONE;
      r.ended = FIELD_NONE;
      r.status = STATUS_ERROR;
    end else if (nx == ST_DONE) begin
      r.status = STATUS_COMPLETE;
    end
    if (s == ST_DONE || s >= ST_ERROR) begin
      r.kind = FIELD_NONE;
      r.ended = FIELD_NONE;
    end
    grammar_pos = nx;
    return r;
  endfunction

  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(0, 16);
  endfunction

  task automatic push_stim(input logic [7:0] c, input logic rs);
    step_row_t row;
    row.data = c;
    row.rs = rs;
    row.typed = 1'b0;
    row.kind = FIELD_NONE;
    row.ended = FIELD_NONE;
    row.status = STATUS_PARSING;
    req_bytes.push_back(row);
  endtask

  // Builds one request head with random content, now and then damaged, cut short or
  // followed by stray bytes.
  task automatic push_request();
    logic [7:0] msg [$];
    int         k;
    int         keep;
    repeat ($urandom_range(0, 6)) msg.push_back(8'($urandom_range(65, 90)));
    msg.push_back(CHAR_SPACE);
    msg.push_back(CHAR_SLASH);
    repeat ($urandom_range(0, 10)) msg.push_back(8'($urandom_range(33, 126)));
    msg.push_back(CHAR_SPACE);
    for (k = 0; k < 8; k++) msg.push_back(VERSION_TEXT[k]);
    msg.push_back(CHAR_CR);
    msg.push_back(CHAR_LF);
    repeat ($urandom_range(0, 4)) begin
      repeat ($urandom_range(1, 6)) msg.push_back(any_name_char());
      msg.push_back(CHAR_COLON);
      msg.push_back(CHAR_SPACE);
      if ($urandom_range(0, 19) != 0) begin
        repeat ($urandom_range(1, 8)) msg.push_back(any_value_char());
      end
      msg.push_back(CHAR_CR);
      msg.push_back(CHAR_LF);
    end
    msg.push_back(CHAR_CR);
    msg.push_back(CHAR_LF);
    if ($urandom_range(0, 4) == 0) begin
      msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom_range(0, 255));
    end
    if ($urandom_range(0, 9) == 0) begin
      keep = $urandom_range(1, msg.size() - 1);
      while (msg.size() > keep) void'(msg.pop_back());
    end
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 4)) msg.push_back(8'($urandom_range(0, 255)));
    end
    for (k = 0; k < msg.size(); k++) begin
      push_stim(msg[k], (k == 0) && ($urandom_range(0, 9) != 0));
    end
  endtask

  task automatic report_mismatch(input string what);
    n_errors++;
    $display("MISMATCH at %0t, result %0d: %s", $realtime, n_checked, what);
  endtask

  task automatic check_field(input string what, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", what, got, want));
  endtask

  initial begin
    byte_tag_t tag;
    int        gap;
    foreach (DIRECTED[i]) req_bytes.push_back(DIRECTED[i]);
    while (req_bytes.size() < DIRECTED_ROWS + RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 12)) begin
          push_stim(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
      end else begin
        push_request();
      end
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (req_bytes[i]) begin
      gap = draw_wait(tx_calm);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid <= 1'b1;
      data_byte <= req_bytes[i].data;
      restart <= req_bytes[i].rs;
      do @(posedge clk); while (in_stall);
      tag = classify_byte(req_bytes[i].data, req_bytes[i].rs);
      if (req_bytes[i].typed) begin
        tag.kind = req_bytes[i].kind;
        tag.ended = req_bytes[i].ended;
        tag.status = req_bytes[i].status;
      end
      pending_tags.push_back(tag);
      n_sent++;
      @(negedge clk);
    end
    in_valid <= 1'b0;
    while (pending_tags.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("Sent %0d request bytes (%0d directed) and checked %0d tagged results.",
             n_sent, DIRECTED_ROWS, n_checked);
    $display("Heads completed: %0d, heads rejected: %0d; output held off twice under load.",
             n_heads, n_rejects);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Receiver side: random stalls, then each item is checked against the oldest expectation.
  initial begin
    byte_tag_t want;
    status_t   last_status;
    int        w;
    last_status = STATUS_PARSING;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      w = draw_wait(rx_calm);
      if (w > 0) begin
        rx_stall <= 1'b1;
        repeat (w) @(negedge clk);
      end
      rx_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
      if (pending_tags.size() == 0) begin
        report_mismatch($sformatf("unexpected item with byte %0h", byte_out));
      end else begin
        want = pending_tags.pop_front();
        check_field("byte_out", byte_out, want.data);
        check_field("field_kind", 8'(field_kind), 8'(want.kind));
        check_field("ended_field", 8'(ended_field), 8'(want.ended));
        check_field("status", 8'(status), 8'(want.status));
        if (want.status != last_status && want.status == STATUS_COMPLETE) n_heads++;
        if (want.status != last_status && want.status == STATUS_ERROR) n_rejects++;
        last_status = want.status;
      end
      n_checked++;
      @(negedge clk);
    end
  end

  // Long output hold-offs while the sender keeps offering items.
  initial begin
    for (int h = 1; h <= 2; h++) begin
      wait (n_sent >= h * 220);
      @(negedge clk);
      hold_off <= 1'b1;
      repeat (200) @(negedge clk);
      hold_off <= 1'b0;
    end
  end

  initial begin
    #1_000_000;
    $display("Timeout: %0d items sent, %0d results still outstanding.",
             n_sent, pending_tags.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
